[rtl/core/cbp_pkg.sv]
`default_nettype none
package cbp_pkg;

	localparam int ACC_BITS    = 24;
	localparam int MAX_WIDTH   = 13;
	localparam int CAP         = (ACC_BITS < 31) ? ACC_BITS : 31;
	localparam int CNT_W       = $clog2(CAP + 1);
	localparam int COEF_W      = 16;
	localparam int BYTE_W      = 8;
	localparam int WID_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 4;
	localparam int MAX_RES     = 8;
	localparam int RES_CNT_W   = $clog2(MAX_RES);
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] FUNC_PACK    = 2'd0;
	localparam logic [1:0] FUNC_UNPACK  = 2'd1;
	localparam logic [1:0] FUNC_COMPARE = 2'd2;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_COEF   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW   = 2'd1;
	localparam logic [1:0] ERR_NO_PENDING = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COMPARE = CFG_IDX_W'(2);

	localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(10);

	// decoded command handed from the front end to the back end
	typedef struct packed {
		logic              is_cmp;
		logic              emit;
		logic [1:0]        kind;
		logic [COEF_W-1:0] data;
		logic [CNT_W-1:0]  bits;
		logic [CNT_W-1:0]  chunk;
		logic              sgn;
		logic              w1;
		logic [BYTE_W-1:0] ref_byte;
	} cmd_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] cnt;
		logic             mis;
	} bst_t;

	function automatic logic [COEF_W-1:0] field_mask(input logic [CNT_W-1:0] w);
		logic [COEF_W:0] one_hot;
		one_hot = (COEF_W + 1)'(1) << w;
		return COEF_W'(one_hot - (COEF_W + 1)'(1));
	endfunction

endpackage
`default_nettype wire

[rtl/core/cbp_in_if.sv]
`default_nettype none
interface cbp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] coefficient;
	logic [7:0]  byte_in;

	modport source (output valid, func, coefficient, byte_in, input ready);
	modport sink (input valid, func, coefficient, byte_in, output ready);
endinterface
`default_nettype wire

[rtl/core/cbp_out_if.sv]
`default_nettype none
interface cbp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] value;
	logic        fail_flag;
	logic [1:0]  error_code;
	logic        last;

	modport source (output valid, kind, value, fail_flag, error_code, last, input ready);
	modport sink (input valid, kind, value, fail_flag, error_code, last, output ready);
endinterface
`default_nettype wire

[rtl/core/cbp_front.sv]
`default_nettype none
module cbp_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	cbp_in_if.sink                              items,
	input  wire logic                           q_ready,
	output cbp_pkg::cmd_t                       cmd,
	output logic                                push,
	input  wire logic                           cfg_we,
	input  wire logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                cfg_clr
);
	import cbp_pkg::*;

	logic [WID_W-1:0]  width_q;
	logic              signed_q;
	logic              compare_q;
	logic [CNT_W-1:0]  eff_w;
	logic [COEF_W-1:0] mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RESET;
			signed_q  <= 1'b0;
			compare_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:   width_q   <= cfg_data[WID_W-1:0];
				REG_SIGNED:  signed_q  <= cfg_data[0];
				REG_COMPARE: compare_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_clr = cfg_we && (cfg_index inside {REG_WIDTH, REG_SIGNED, REG_COMPARE});

	// clamp width into 1..MAX_WIDTH
	always_comb begin
		if (width_q == '0)
			eff_w = CNT_W'(1);
		else if (CNT_W'(width_q) > CNT_W'(MAX_WIDTH))
			eff_w = CNT_W'(MAX_WIDTH);
		else
			eff_w = CNT_W'(width_q);
	end

	assign mask        = field_mask(eff_w);
	assign items.ready = q_ready;
	// func 3 is taken and dropped here
	assign push = items.valid && q_ready &&
		(items.func inside {FUNC_PACK, FUNC_UNPACK, FUNC_COMPARE});

	always_comb begin
		cmd = '0;
		case (items.func)
			FUNC_PACK: begin
				cmd.emit  = !compare_q;
				cmd.kind  = KIND_BYTE;
				cmd.data  = items.coefficient & mask;
				cmd.bits  = eff_w;
				cmd.chunk = CNT_W'(BYTE_W);
			end
			FUNC_UNPACK: begin
				cmd.emit  = 1'b1;
				cmd.kind  = KIND_COEF;
				cmd.data  = COEF_W'(items.byte_in);
				cmd.bits  = CNT_W'(BYTE_W);
				cmd.chunk = eff_w;
				cmd.sgn   = signed_q;
				cmd.w1    = (eff_w == CNT_W'(1));
			end
			FUNC_COMPARE: begin
				cmd.is_cmp   = 1'b1;
				cmd.kind     = KIND_STATUS;
				cmd.ref_byte = items.byte_in;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/cbp_queue.sv]
`default_nettype none
module cbp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire cbp_pkg::cmd_t  wr_cmd,
	output logic                ready,
	input  wire logic           pop,
	output cbp_pkg::cmd_t       rd_cmd,
	output logic                head_valid
);
	import cbp_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign ready      = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign do_push    = push && ready;
	assign do_pop     = pop && head_valid;
	assign rd_cmd     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/core/cbp_back.sv]
`default_nettype none
module cbp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clr,
	input  wire logic          head_valid,
	input  wire cbp_pkg::cmd_t cmd,
	output logic               pop,
	output cbp_pkg::bst_t      status,
	cbp_out_if.source          results
);
	import cbp_pkg::*;

	logic [ACC_BITS-1:0]  acc_q, acc_d, acc_m, src_acc;
	logic [CNT_W-1:0]     cnt_q, cnt_d, src_cnt, rem_cnt;
	logic [CNT_W:0]       sum_cnt;
	logic                 mis_q, mis_d;
	logic                 busy_q, busy_d;
	logic [RES_CNT_W-1:0] res_cnt_q, res_cnt_d;

	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [COEF_W-1:0]    out_value_q;
	logic                 out_fail_q;
	logic [1:0]           out_err_q;
	logic                 out_last_q;

	logic                 out_free, step, ovf, have, cont, neg;
	logic [COEF_W-1:0]    m, field, coef_val;
	logic [BYTE_W-1:0]    held;
	logic                 res_valid, res_last;
	logic [1:0]           res_kind, res_err;
	logic [COEF_W-1:0]    res_value;

	assign out_free = !out_valid_q || results.ready;
	assign step     = head_valid && out_free;

	// merge the new bits on the first beat of a command, reuse the state after that
	assign sum_cnt  = {1'b0, cnt_q} + {1'b0, cmd.bits};
	assign ovf      = !busy_q && !cmd.is_cmp && (sum_cnt > (CNT_W + 1)'(CAP));
	assign acc_m    = acc_q | (ACC_BITS'(cmd.data) << cnt_q);
	assign src_acc  = busy_q ? acc_q : acc_m;
	assign src_cnt  = busy_q ? cnt_q : sum_cnt[CNT_W-1:0];
	assign rem_cnt  = src_cnt - cmd.chunk;
	assign have     = (src_cnt >= cmd.chunk);
	assign cont     = (rem_cnt >= cmd.chunk) && (res_cnt_q != RES_CNT_W'(MAX_RES - 1));

	assign m        = field_mask(cmd.chunk);
	assign field    = src_acc[COEF_W-1:0] & m;
	assign neg      = cmd.sgn && |(field & (m ^ (m >> 1)));
	assign coef_val = cmd.w1 ? src_acc[COEF_W-1:0] : (neg ? (field | ~m) : field);
	assign held     = acc_q[BYTE_W-1:0];

	always_comb begin
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		mis_d     = mis_q;
		busy_d    = busy_q;
		res_cnt_d = res_cnt_q;
		pop       = 1'b0;
		res_valid = 1'b0;
		res_kind  = KIND_BYTE;
		res_value = '0;
		res_err   = ERR_NONE;
		res_last  = 1'b1;
		if (step) begin
			if (cmd.is_cmp) begin
				pop       = 1'b1;
				res_valid = 1'b1;
				if (cnt_q < CNT_W'(BYTE_W)) begin
					res_kind = KIND_ERROR;
					res_err  = ERR_NO_PENDING;
				end else begin
					res_kind  = KIND_STATUS;
					res_value = COEF_W'(held);
					mis_d     = mis_q | (held != cmd.ref_byte);
					acc_d     = acc_q >> BYTE_W;
					cnt_d     = cnt_q - CNT_W'(BYTE_W);
				end
			end else if (ovf) begin
				pop       = 1'b1;
				res_valid = 1'b1;
				res_kind  = KIND_ERROR;
				res_err   = ERR_OVERFLOW;
			end else if (cmd.emit && have) begin
				res_valid = 1'b1;
				res_kind  = cmd.kind;
				res_value = coef_val;
				acc_d     = src_acc >> cmd.chunk;
				cnt_d     = rem_cnt;
				busy_d    = cont;
				res_cnt_d = cont ? res_cnt_q + 1'b1 : '0;
				res_last  = !cont;
				pop       = !cont;
			end else begin
				// bits stay pending
				pop   = 1'b1;
				acc_d = src_acc;
				cnt_d = src_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			mis_q       <= 1'b0;
			busy_q      <= 1'b0;
			res_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr) begin
				acc_q     <= '0;
				cnt_q     <= '0;
				mis_q     <= 1'b0;
				busy_q    <= 1'b0;
				res_cnt_q <= '0;
			end else begin
				acc_q     <= acc_d;
				cnt_q     <= cnt_d;
				mis_q     <= mis_d;
				busy_q    <= busy_d;
				res_cnt_q <= res_cnt_d;
			end
			if (out_free)
				out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_kind_q  <= res_kind;
			out_value_q <= res_value;
			out_fail_q  <= mis_d;
			out_err_q   <= res_err;
			out_last_q  <= res_last;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.kind       = out_kind_q;
	assign results.value      = out_value_q;
	assign results.fail_flag  = out_fail_q;
	assign results.error_code = out_err_q;
	assign results.last       = out_last_q;

	assign status.busy = busy_q;
	assign status.cnt  = cnt_q;
	assign status.mis  = mis_q;
endmodule
`default_nettype wire

[rtl/core/coefficient_bit_packer.sv]
// Flow: a taken item passes through the command queue, and its first result is registered at the output.
// Throughput: one item per cycle while each item gives at most one result and the output
// is free; k results of one item (narrow unpack widths) hold the back end, one at a time.
// A two-entry command queue sits between the decode front end and the accumulator back end.
// Reset: asynchronous, active low; registers return to their defaults, accumulator, bit
// count and mismatch flag clear at once.
`default_nettype none
module coefficient_bit_packer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	cbp_in_if.sink                              items,
	cbp_out_if.source                           results,
	input  wire logic                           cfg_we,
	input  wire logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cbp_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	bst_t status;
	logic push;
	logic q_ready;
	logic q_valid;
	logic pop;
	logic cfg_clr;

	cbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.q_ready   (q_ready),
		.cmd       (push_cmd),
		.push      (push),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_clr   (cfg_clr)
	);

	cbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_cmd     (push_cmd),
		.ready      (q_ready),
		.pop        (pop),
		.rd_cmd     (head_cmd),
		.head_valid (q_valid)
	);

	cbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (cfg_clr),
		.head_valid (q_valid),
		.cmd        (head_cmd),
		.pop        (pop),
		.status     (status),
		.results    (results)
	);

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		status.cnt <= CNT_W'(CAP))
		else $error("bit count beyond accumulator capacity");

	a_busy_head: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> q_valid)
		else $error("back end continues without a queued command");

	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty command queue");

	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_clr |=> (status.cnt == '0 && !status.mis && !status.busy))
		else $error("register write did not clear accumulator state");
endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import cbp_pkg::*;

	localparam logic [1:0] FUNC_IGNORED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 120;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 20;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic        fail;
		logic [1:0]  err;
		logic        last;
	} res_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_op_t;

	typedef struct packed {
		row_op_t                op;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic [1:0]             f;
		logic [15:0]            coef;
		logic [7:0]             byt;
		logic                   typed;
		logic [1:0]             kind;
		logic [15:0]            value;
		logic [1:0]             err;
		logic                   fail;
	} plan_row_t;

	// directed rows; typed rows carry their single result, the rest go through the predictor
	localparam int PLAN_LEN = 31;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_COMPARE, 16'h0000, 8'h00,
			1'b1, KIND_ERROR, 16'h0000, ERR_NO_PENDING, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_PACK, 16'hFFFF, 8'h00,
			1'b1, KIND_BYTE, 16'h00FF, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_PACK, 16'h0000, 8'hFF,
			1'b1, KIND_BYTE, 16'h0003, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_PACK, 16'h8001, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_UNPACK, 16'h0000, 8'hFF,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_IGNORED, 16'hFFFF, 8'hFF,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_COMPARE, 16'h0000, 8'h00,
			1'b1, KIND_ERROR, 16'h0000, ERR_NO_PENDING, 1'b0},
		'{ROW_REG, REG_UNUSED, 4'hF, FUNC_PACK, 16'h0000, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_UNPACK, 16'h0000, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_REG, REG_WIDTH, 4'h1, FUNC_PACK, 16'h0000, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_PACK, 16'hFFFF, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_PACK, 16'h0000, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_PACK, 16'hFFFF, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		// width one, three bits held: eight results and the rest stays behind
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_UNPACK, 16'h0000, 8'hA5,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_REG, REG_WIDTH, 4'hD, FUNC_PACK, 16'h0000, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_REG, REG_SIGNED, 4'h1, FUNC_PACK, 16'h0000, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_UNPACK, 16'h0000, 8'hFF,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_UNPACK, 16'h0000, 8'hFF,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_UNPACK, 16'h0000, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_REG, REG_COMPARE, 4'h1, FUNC_PACK, 16'h0000, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_PACK, 16'h1FFF, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_PACK, 16'h0000, 8'h00,
			1'b1, KIND_ERROR, 16'h0000, ERR_OVERFLOW, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_COMPARE, 16'h0000, 8'hFF,
			1'b1, KIND_STATUS, 16'h00FF, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_COMPARE, 16'h0000, 8'h00,
			1'b1, KIND_ERROR, 16'h0000, ERR_NO_PENDING, 1'b0},
		'{ROW_REG, REG_WIDTH, 4'h8, FUNC_PACK, 16'h0000, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_PACK, 16'h005A, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_PACK, 16'hFFC3, 8'h00,
			1'b0, KIND_BYTE, 16'h0000, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_COMPARE, 16'h0000, 8'h5A,
			1'b1, KIND_STATUS, 16'h005A, ERR_NONE, 1'b0},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_COMPARE, 16'h0000, 8'h00,
			1'b1, KIND_STATUS, 16'h00C3, ERR_NONE, 1'b1},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_COMPARE, 16'h0000, 8'h00,
			1'b1, KIND_ERROR, 16'h0000, ERR_NO_PENDING, 1'b1},
		'{ROW_ITEM, REG_WIDTH, 4'h0, FUNC_UNPACK, 16'h0000, 8'h81,
			1'b1, KIND_COEF, 16'hFF81, ERR_NONE, 1'b1}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cbp_in_if items_ch();
	cbp_out_if results_ch();

	coefficient_bit_packer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// packer state as the predictor sees it
	logic [3:0]  m_width;
	logic        m_signed;
	logic        m_cmp;
	logic [63:0] m_acc;
	int unsigned m_cnt;
	logic        m_mis;

	res_t step_res[$];
	res_t expect_q[$];

	int unsigned items_sent = 0;
	int unsigned results_checked = 0;
	int unsigned reg_writes = 0;
	int unsigned mismatches = 0;
	int unsigned holds_asked = 0;
	bit tx_jitter = 1'b1;
	bit rx_jitter = 1'b1;

	function automatic int unsigned pick_gap(input bit enabled);
		int unsigned r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned coef_bits();
		int unsigned w;
		w = m_width;
		if (w == 0)
			w = 1;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		return w;
	endfunction

	function automatic void clear_packer();
		m_acc = '0;
		m_cnt = 0;
		m_mis = 1'b0;
	endfunction

	function automatic void add_res(input logic [1:0] kind, input logic [15:0] value,
		input logic [1:0] err);
		res_t r;
		r = '{kind, value, m_mis, err, 1'b0};
		step_res.push_back(r);
	endfunction

	function automatic void predict_item(input logic [1:0] f, input logic [15:0] c,
		input logic [7:0] b);
		int unsigned w;
		logic [63:0] mask;
		logic [15:0] v;
		logic [7:0] held;
		step_res.delete();
		w = coef_bits();
		mask = (64'd1 << w) - 64'd1;
		case (f)
			FUNC_PACK: begin
				if (m_cnt + w > CAP) begin
					add_res(KIND_ERROR, 16'h0000, ERR_OVERFLOW);
				end else begin
					m_acc |= (64'(c) & mask) << m_cnt;
					m_cnt += w;
					// compare mode keeps bytes pending
					if (!m_cmp) begin
						while (m_cnt >= 8 && step_res.size() < MAX_RES) begin
							add_res(KIND_BYTE, {8'h00, m_acc[7:0]}, ERR_NONE);
							m_acc >>= 8;
							m_cnt -= 8;
						end
					end
				end
			end
			FUNC_UNPACK: begin
				if (m_cnt + 8 > CAP) begin
					add_res(KIND_ERROR, 16'h0000, ERR_OVERFLOW);
				end else begin
					m_acc |= 64'(b) << m_cnt;
					m_cnt += 8;
					while (m_cnt >= w && step_res.size() < MAX_RES) begin
						// width one hands out the raw accumulator
						if (w == 1) begin
							v = m_acc[15:0];
						end else begin
							v = 16'(m_acc & mask);
							if (m_signed && v[w-1])
								v |= ~16'(mask);
						end
						add_res(KIND_COEF, v, ERR_NONE);
						m_acc >>= w;
						m_cnt -= w;
					end
				end
			end
			FUNC_COMPARE: begin
				if (m_cnt < 8) begin
					add_res(KIND_ERROR, 16'h0000, ERR_NO_PENDING);
				end else begin
					held = m_acc[7:0];
					if (held != b)
						m_mis = 1'b1;
					m_acc >>= 8;
					m_cnt -= 8;
					add_res(KIND_STATUS, {8'h00, held}, ERR_NONE);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_expect(input bit typed, input res_t hand);
		res_t r;
		if (typed) begin
			hand.last = 1'b1;
			expect_q.push_back(hand);
		end else begin
			for (int i = 0; i < step_res.size(); i++) begin
				r = step_res[i];
				r.last = (i == step_res.size() - 1);
				expect_q.push_back(r);
			end
		end
	endfunction

	task automatic send_item(input logic [1:0] f, input logic [15:0] c, input logic [7:0] b,
		input bit typed, input res_t hand);
		int unsigned gap;
		gap = pick_gap(tx_jitter);
		if (gap != 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.func <= f;
		items_ch.coefficient <= c;
		items_ch.byte_in <= b;
		@(posedge clk);
		while (!items_ch.ready)
			@(posedge clk);
		items_sent++;
		predict_item(f, c, b);
		queue_expect(typed, hand);
	endtask

	// drop valid, drain every result, then give in-flight silent items time to land
	task automatic settle();
		items_ch.valid <= 1'b0;
		while (expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		bit known;
		known = 1'b1;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
		case (idx)
			REG_WIDTH: m_width = data;
			REG_SIGNED: m_signed = data[0];
			REG_COMPARE: m_cmp = data[0];
			default: known = 1'b0;
		endcase
		if (known)
			clear_packer();
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_beat
		res_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (expect_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected nothing, got kind %0d value %h",
					$time, results_ch.kind, results_ch.value);
			end else begin
				want = expect_q.pop_front();
				results_checked++;
				check_field("kind", 16'(want.kind), 16'(results_ch.kind));
				check_field("value", want.value, results_ch.value);
				check_field("fail_flag", 16'(want.fail), 16'(results_ch.fail_flag));
				check_field("error_code", 16'(want.err), 16'(results_ch.error_code));
				check_field("last", 16'(want.last), 16'(results_ch.last));
			end
		end
	end

	// result side: random stalls plus a long hold when asked
	initial begin : result_sink
		int unsigned holds_done;
		int unsigned stall;
		holds_done = 0;
		results_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (holds_done != holds_asked) begin
				holds_done++;
				results_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = pick_gap(rx_jitter);
				if (stall != 0) begin
					results_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end else begin
					results_ch.ready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned r;
		int unsigned w;
		logic [1:0] f;
		logic [15:0] c;
		logic [7:0] b;
		logic [3:0] wsel;
		logic [3:0] sd;
		logic [3:0] cd;
		res_t none;
		res_t hand;
		none = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items_ch.valid = 1'b0;
		items_ch.func = FUNC_PACK;
		items_ch.coefficient = '0;
		items_ch.byte_in = '0;
		m_width = WIDTH_RESET;
		m_signed = 1'b0;
		m_cmp = 1'b0;
		clear_packer();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int k = 0; k < PLAN_LEN; k++) begin
			if (PLAN[k].op == ROW_REG) begin
				settle();
				write_reg(PLAN[k].idx, PLAN[k].data);
			end else begin
				hand = '{PLAN[k].kind, PLAN[k].value, PLAN[k].fail, PLAN[k].err, 1'b1};
				send_item(PLAN[k].f, PLAN[k].coef, PLAN[k].byt, PLAN[k].typed, hand);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: wsel = 4'd1;
				1: wsel = 4'd13;
				2: wsel = 4'd0;
				3: wsel = 4'd15;
				4: wsel = 4'd2;
				default: wsel = 4'($urandom_range(0, 15));
			endcase
			sd = 4'($urandom_range(0, 15));
			cd = 4'($urandom_range(0, 15));
			cd[0] = (ph % 3 == 2);
			settle();
			write_reg(REG_WIDTH, wsel);
			write_reg(REG_SIGNED, sd);
			write_reg(REG_COMPARE, cd);
			tx_jitter = !(ph == 1 || ph == 5);
			rx_jitter = !(ph == 1 || ph == 4);
			// stall the output for a long stretch while items keep coming
			if (ph == 5)
				holds_asked++;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				w = coef_bits();
				r = $urandom_range(0, 99);
				c = 16'($urandom());
				b = 8'($urandom());
				if (r < 10) begin
					f = 2'($urandom_range(0, 3));
				end else if (m_cmp) begin
					// compare against what is pending, now and then with a wrong byte
					if (m_cnt >= 8 && (m_cnt + w > CAP || $urandom_range(0, 2) == 0)) begin
						f = FUNC_COMPARE;
						if ($urandom_range(0, 9) != 0)
							b = m_acc[7:0];
					end else begin
						f = FUNC_PACK;
					end
				end else if (r < 55) begin
					f = FUNC_PACK;
				end else begin
					f = FUNC_UNPACK;
				end
				send_item(f, c, b, 1'b0, none);
			end
		end

		items_ch.valid <= 1'b0;
		while (expect_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d items and %0d result beats across %0d register writes",
			items_sent, results_checked, reg_writes);
		$display("Widths from 0 to 15, signed and compare modes, and one long output hold");
		if (mismatches == 0 && expect_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
